>>> src/tspsa_pkg.sv
// shared types and constants for the transport stream packet sync aligner
package tspsa_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int BYTE_W       = 8;
    localparam int POS_W        = 8;
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h47;
    localparam int PTR_W        = $clog2(PACKET_BYTES);
    localparam int CNT_W        = $clog2(PACKET_BYTES + 1);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // one result byte with its packet position and marks
    typedef struct packed {
        logic [BYTE_W-1:0] packet_byte;
        logic [POS_W-1:0]  byte_position;
        logic              is_first;
        logic              is_last;
    } t_item;

    // push from the front into the queue
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

endpackage

>>> src/ts_packet_sync_aligner.sv
// top level of the transport stream packet sync aligner
//
//  channel   | direction | payload                                 | beat when
//  s_axis    | in        | tdata[7:0] stream byte                  | tvalid & tready
//  m_axis    | out       | tdata[7:0] byte, [15:8] position,       | tvalid & tready
//            |           | tuser first mark, tlast last mark       |
//  cfg       | in        | i_cfg_data[7:0] sync value              | i_cfg_valid & o_cfg_ready
//
//  one input beat per cycle sustained while the queue has space; the beat that confirms a
//  packet start is pushed into the queue and then loaded into the output register
//  the delay line is a 188 entry single write, single read memory; its read is
//  issued ahead at the next write address so the oldest byte is waiting in a register
//  synchronous active low reset; no clearing pass, the line is only read once
//  it has been filled, so the first 188 beats are absorbed without output
//  a four entry queue decouples the input from the output register; s_axis
//  stalls only while that queue is full
module ts_packet_sync_aligner
    import tspsa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [BYTE_W-1:0]       s_axis_tdata,   // [7:0] stream_byte
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [BYTE_W+POS_W-1:0] m_axis_tdata,   // [7:0] packet_byte, [15:8] byte_position
    output logic                    m_axis_tuser,   // [0] is_first
    output logic                    m_axis_tlast,   // is_last
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [BYTE_W-1:0]       i_cfg_data      // [7:0] sync_value
);

    t_push push;
    logic  space;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    // config writes are always taken, the new value applies to the next start check
    assign o_cfg_ready = 1'b1;

    // delay line and sync detection
    tspsa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_space     (space),
        .o_push      (push)
    );

    // decoupling queue
    tspsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // output register
    tspsa_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

    // first mark only on position zero
    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[15:8] == '0))
        else $error("first mark away from position zero");

    // last mark only on the final position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tdata[15:8] == POS_W'(PACKET_BYTES - 1)))
        else $error("last mark away from final position");

    // a byte is never both opening and closing a packet
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser && m_axis_tlast))
        else $error("byte marked first and last");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

>>> src/tspsa_front.sv
// front end: packet delay line, sync confirmation and packet position tracking
module tspsa_front
    import tspsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_cfg_valid,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_space,
    output t_push             o_push
);

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(PACKET_BYTES - 1);
    localparam logic [CNT_W-1:0] PKT_LEN  = CNT_W'(PACKET_BYTES);

    logic [BYTE_W-1:0] mem [PACKET_BYTES];
    logic [BYTE_W-1:0] r_rd_data;
    logic [PTR_W-1:0]  r_wptr, n_wptr, rd_addr;
    logic              r_full, n_full;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [BYTE_W-1:0] r_sync;
    logic              accept;
    logic              match;
    logic              emit;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    // oldest byte sits at the write pointer once the line is full
    assign n_wptr  = (r_wptr == LAST_PTR) ? '0 : r_wptr + PTR_W'(1);
    assign rd_addr = accept ? n_wptr : r_wptr;

    assign match = (r_left == '0) && (r_rd_data == r_sync) && (i_byte == r_sync);
    assign emit  = accept && r_full && ((r_left != '0) || match);

    always_comb begin
        n_full = r_full;
        n_left = r_left;
        if (accept) begin
            if (r_wptr == LAST_PTR) begin
                n_full = 1'b1;
            end
            if (emit) begin
                n_left = (r_left == '0) ? PKT_LEN - CNT_W'(1) : r_left - CNT_W'(1);
            end
        end
    end

    always_comb begin
        o_push.valid              = emit;
        o_push.item.packet_byte   = r_rd_data;
        o_push.item.byte_position = (r_left == '0) ? '0 : POS_W'(PKT_LEN - r_left);
        o_push.item.is_first      = (r_left == '0);
        o_push.item.is_last       = (r_left == CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[r_wptr] <= i_byte;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_full <= 1'b0;
            r_left <= '0;
            r_sync <= BYTE_W'(SYNC_RESET);
        end else begin
            if (accept) begin
                r_wptr <= n_wptr;
            end
            r_full <= n_full;
            r_left <= n_left;
            if (i_cfg_valid) begin
                r_sync <= i_cfg_data;
            end
        end
    end

endmodule

>>> src/tspsa_queue.sv
// short queue between the front end and the output stage
module tspsa_queue
    import tspsa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_space,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_space = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push.valid) - QCNT_W'(do_pop);
        end
    end

endmodule

>>> src/tspsa_back.sv
// output stage: registers queued bytes and drives the master stream
module tspsa_back
    import tspsa_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_item                     i_item,
    output logic                      o_pop,
    output logic                      o_tvalid,
    input  logic                      i_tready,
    output logic [BYTE_W+POS_W-1:0]   o_tdata,
    output logic                      o_tuser,
    output logic                      o_tlast
);

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign load  = !r_valid || i_tready;
    assign o_pop = load && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {r_item.byte_position, r_item.packet_byte};
    assign o_tuser  = r_item.is_first;
    assign o_tlast  = r_item.is_last;

endmodule

>>> tb/tb.sv
// self-checking testbench for the transport stream packet sync aligner
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tspsa_pkg::*;

    localparam int RANDOM_ITEMS   = 100;   // stream beats in the random part
    localparam int SETTLE_CYCLES  = 8;     // covers the start latency and the queue
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off, far beyond the queue depth
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat on any channel
    localparam int REPORT_LINES   = 40;    // mismatch lines printed before going quiet

    // receiver stall patterns
    typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_SPARSE} t_rx_style;
    // packet body fill
    typedef enum int {PAY_RANDOM, PAY_SYNC, PAY_EDGE} t_payload;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [BYTE_W-1:0]       s_axis_tdata  = '0;   // [7:0] stream_byte
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [BYTE_W+POS_W-1:0] m_axis_tdata;         // [7:0] packet_byte, [15:8] byte_position
    logic                    m_axis_tuser;         // [0] is_first
    logic                    m_axis_tlast;         // is_last
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [BYTE_W-1:0]       i_cfg_data    = '0;   // [7:0] sync_value

    // aligner mirror: delay line (oldest first), packet countdown, sync byte
    logic [BYTE_W-1:0] line_q[$];
    logic [POS_W-1:0]  packet_left = '0;
    logic [BYTE_W-1:0] sync_track  = SYNC_RESET;
    t_item             awaited[$];      // packet bytes still to come out, oldest first

    int                err_count    = 0;
    int                items_sent   = 0;
    int                burst_left   = 0;
    bit                tx_gaps_on   = 1'b1;
    logic [BYTE_W-1:0] cur_sync     = SYNC_RESET;  // sync value the stimulus formats with
    int                rx_hold_left = 0;
    int                rx_phase_left = 0;
    int                rx_tick      = 0;
    t_rx_style         rx_style     = RX_STEADY;

    ts_packet_sync_aligner DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        if (err_count < REPORT_LINES) begin
            $display("%0t ns mismatch: %s", $realtime, what);
        end
        err_count++;
    endtask

    // one stream beat through the mirrored delay line; queues the packet byte it releases
    function automatic void advance_aligner(input logic [BYTE_W-1:0] incoming);
        logic [BYTE_W-1:0] oldest;
        t_item             beat_exp;
        // line still filling, nothing leaves
        if (line_q.size() < PACKET_BYTES) begin
            line_q.push_back(incoming);
            return;
        end
        oldest = line_q.pop_front();
        line_q.push_back(incoming);
        // outside a packet the leaving byte and the one a packet later must both be sync
        if (packet_left == 0) begin
            if (oldest != sync_track || incoming != sync_track) begin
                return;
            end
            packet_left = POS_W'(PACKET_BYTES);
        end
        // inside a packet every byte goes out unchecked
        beat_exp.packet_byte   = oldest;
        beat_exp.byte_position = POS_W'(PACKET_BYTES) - packet_left;
        beat_exp.is_first      = (packet_left == POS_W'(PACKET_BYTES));
        beat_exp.is_last       = (packet_left == 1);
        packet_left--;
        awaited.push_back(beat_exp);
    endfunction

    // compare one output beat with the oldest pending packet byte
    task automatic check_beat();
        t_item got;
        t_item want;
        got.packet_byte   = m_axis_tdata[BYTE_W-1:0];
        got.byte_position = m_axis_tdata[BYTE_W+POS_W-1:BYTE_W];
        got.is_first      = m_axis_tuser;
        got.is_last       = m_axis_tlast;
        if (awaited.size() == 0) begin
            report_mismatch($sformatf("beat %02h pos %0d with no packet byte pending",
                got.packet_byte, got.byte_position));
            return;
        end
        want = awaited.pop_front();
        if (got.packet_byte !== want.packet_byte) begin
            report_mismatch($sformatf("packet_byte %02h, want %02h at pos %0d",
                got.packet_byte, want.packet_byte, want.byte_position));
        end
        if (got.byte_position !== want.byte_position) begin
            report_mismatch($sformatf("byte_position %0d, want %0d",
                got.byte_position, want.byte_position));
        end
        if (got.is_first !== want.is_first) begin
            report_mismatch($sformatf("is_first %b, want %b at pos %0d",
                got.is_first, want.is_first, want.byte_position));
        end
        if (got.is_last !== want.is_last) begin
            report_mismatch($sformatf("is_last %b, want %b at pos %0d",
                got.is_last, want.is_last, want.byte_position));
        end
    endtask

    // monitor: all channels sampled at the rising edge, prediction before checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sync_track = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_aligner(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_beat();
            end
        end
    end

    // receiver: a long hold-off when asked, otherwise stall patterns that change by themselves
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left--;
        end else begin
            if (rx_phase_left == 0) begin
                rx_style      = t_rx_style'($urandom_range(0, 3));
                rx_phase_left = $urandom_range(32, 256);
            end
            rx_phase_left--;
            rx_tick++;
            case (rx_style)
                RX_STEADY:   m_axis_tready <= 1'b1;
                RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: m_axis_tready <= ((rx_tick % 5) < 3);
                default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog: ends the run when no beat moves on any channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // send one stream beat; called and returns at a falling edge, tvalid held within a burst
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        @(negedge i_clk);
        // bursts of random length with random gaps between them
        if (tx_gaps_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
                burst_left = $urandom_range(1, 48);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_noise(input int count);
        for (int k = 0; k < count; k++) begin
            send_byte(BYTE_W'($urandom));
        end
    endtask

    // well-formed packets: sync byte then PACKET_BYTES-1 body bytes
    task automatic send_packets(input int count, input logic [BYTE_W-1:0] sync_b,
                                input t_payload style);
        for (int p = 0; p < count; p++) begin
            send_byte(sync_b);
            for (int k = 1; k < PACKET_BYTES; k++) begin
                case (style)
                    PAY_SYNC: send_byte(sync_b);
                    PAY_EDGE: send_byte(k[0] ? 8'hFF : 8'h00);
                    default: begin
                        // body bytes equal to sync now and then, to show they go unchecked
                        if ($urandom_range(0, 15) == 0) begin
                            send_byte(sync_b);
                        end else begin
                            send_byte(BYTE_W'($urandom));
                        end
                    end
                endcase
            end
        end
    endtask

    // sender pause: stop offering, wait for every pending byte, then let the block settle
    task automatic wait_drained();
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
        end
        while (awaited.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // sync register write, only with the block idle
    task automatic write_sync(input logic [BYTE_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_sync = value;
        @(negedge i_clk);
    endtask

    // reset sync value; the first line of bytes is absorbed, then the next sync confirms it
    task automatic test_fill_and_align();
        tx_gaps_on = 1'b1;
        send_packets(1, SYNC_RESET, PAY_EDGE);
        send_byte(SYNC_RESET);
        wait_drained();
    endtask

    // bodies made only of sync bytes: no check inside a packet, next start checked right after
    task automatic test_payload_unchecked();
        tx_gaps_on = 1'b0;
        send_packets(1, cur_sync, PAY_SYNC);
        send_byte(cur_sync);
        send_noise(20);
        wait_drained();
    endtask

    // sync leaving without a sync one packet later, and the reverse, then realignment
    task automatic test_misaligned_starts();
        tx_gaps_on = 1'b1;
        send_packets(1, cur_sync, PAY_RANDOM);
        send_noise(7);
        send_packets(1, cur_sync, PAY_RANDOM);
        send_byte(cur_sync);
        wait_drained();
    endtask

    // sync value at 0x00: an all-zero stream opens a packet at every chance
    task automatic test_sync_extremes();
        write_sync(8'h00);
        tx_gaps_on = 1'b1;
        send_packets(1, 8'h00, PAY_SYNC);
        send_byte(8'h00);
        send_noise(30);
        wait_drained();
    endtask

    // sync at 0xFF, a packet left half done, then the value changes under it
    task automatic test_sync_change_mid_packet();
        write_sync(8'hFF);
        send_packets(1, 8'hFF, PAY_EDGE);
        send_byte(8'hFF);
        send_noise(60);
        // the 0xFF packet must finish as it started, the new value counts from the next start
        write_sync(SYNC_RESET);
        send_packets(1, SYNC_RESET, PAY_RANDOM);
        send_byte(SYNC_RESET);
        wait_drained();
    endtask

    // receiver holds off long enough to fill the output queue and stall the input
    task automatic test_backpressure();
        tx_gaps_on   = 1'b0;
        rx_hold_left = HOLD_CYCLES;
        send_packets(1, cur_sync, PAY_RANDOM);
        send_byte(cur_sync);
        wait_drained();
    endtask

    // mostly well-formed packets, with noise, truncated packets and sync changes mixed in
    task automatic test_random_stream();
        int start;
        int pick;
        start      = items_sent;
        tx_gaps_on = 1'b1;
        while (items_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                case ($urandom_range(0, 3))
                    0:       write_sync(8'h00);
                    1:       write_sync(8'hFF);
                    2:       write_sync(SYNC_RESET);
                    default: write_sync(BYTE_W'($urandom));
                endcase
            end else if (pick <= 7) begin
                send_packets($urandom_range(1, 3), cur_sync, PAY_RANDOM);
            end else if (pick == 8) begin
                send_noise($urandom_range(1, 40));
            end else if (pick == 9) begin
                // packet cut short
                send_byte(cur_sync);
                send_noise($urandom_range(0, PACKET_BYTES - 2));
            end else if (pick == 10) begin
                // slipped packet: one stray beat ahead of it
                send_noise(1);
                send_packets(1, cur_sync, PAY_RANDOM);
            end else begin
                wait_drained();
                tx_gaps_on = $urandom_range(0, 1);
            end
        end
        send_byte(cur_sync);
    endtask

    initial begin
        // synchronous reset held from the start, released at a falling edge
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_fill_and_align();
        test_payload_unchecked();
        test_misaligned_starts();
        test_sync_extremes();
        test_sync_change_mid_packet();
        test_backpressure();
        test_random_stream();

        // drain, then leave room for any stray beat
        wait_drained();
        repeat (4 * SETTLE_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
